// ----- hdl/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the subnet packet forwarder.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int PORTS  = 16;
    localparam int GROUPS = 16;
    localparam int IDX_W  = $clog2(PORTS);

    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [31:0] MC_NIBBLE_MASK = 32'hF000_0000;
    localparam logic [31:0] MC_NIBBLE      = 32'hE000_0000;

    localparam logic [2:0] CMD_ROUTE       = 3'd0;
    localparam logic [2:0] CMD_CONNECT     = 3'd1;
    localparam logic [2:0] CMD_DISCONNECT  = 3'd2;
    localparam logic [2:0] CMD_SUBSCRIBE   = 3'd3;
    localparam logic [2:0] CMD_UNSUBSCRIBE = 3'd4;

    localparam logic [2:0] ACT_DROP      = 3'd0;
    localparam logic [2:0] ACT_UNICAST   = 3'd1;
    localparam logic [2:0] ACT_BROADCAST = 3'd2;
    localparam logic [2:0] ACT_MULTICAST = 3'd3;
    localparam logic [2:0] ACT_PASS_UP   = 3'd4;
    localparam logic [2:0] ACT_UPSTREAM  = 3'd5;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_DEVICE   = 3'd1;
    localparam logic [2:0] ST_NO_LISTENER = 3'd2;
    localparam logic [2:0] ST_NO_ADDRESS  = 3'd3;
    localparam logic [2:0] ST_DUPLICATE   = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;
    localparam logic [2:0] ST_ALREADY     = 3'd6;

    localparam logic [1:0] REG_SUBNET       = 2'd0;
    localparam logic [1:0] REG_SUBNET_MASK  = 2'd1;
    localparam logic [1:0] REG_HAS_UPSTREAM = 2'd2;
    localparam logic [1:0] REG_SAME_NET     = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        logic        in_map;
        logic        connected;
        logic        grp_valid;
        logic        use_group;
    } scan_entry_t;

    typedef struct packed {
        logic             map_v;
        logic [IDX_W-1:0] map_idx;
        logic             conn_v;
        logic [IDX_W-1:0] conn_idx;
        logic             grp_v;
        logic [IDX_W-1:0] grp_idx;
        logic             free_v;
        logic [IDX_W-1:0] free_idx;
    } scan_hits_t;

endpackage

// ----- hdl/spf_if.sv -----
// ----------------------------------------------------------------------------
// spf_if
// Request, result and configuration channels of the subnet packet forwarder.
// ----------------------------------------------------------------------------
interface spf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] address;
    logic [3:0]  port;
    logic        from_upstream;

    modport source (output valid, cmd, address, port, from_upstream, input ready);
    modport sink   (input valid, cmd, address, port, from_upstream, output ready);
endinterface

interface spf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] port_mask;
    logic        to_children;
    logic [2:0]  status;
    logic [31:0] unicast_count;
    logic [31:0] multicast_count;
    logic [31:0] upstream_count;

    modport source (output valid, action, port_mask, to_children, status,
                    unicast_count, multicast_count, upstream_count, input ready);
    modport sink   (input valid, action, port_mask, to_children, status,
                    unicast_count, multicast_count, upstream_count, output ready);
endinterface

interface spf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/subnet_packet_forwarder.sv -----
// ----------------------------------------------------------------------------
// subnet_packet_forwarder
// Forwarding decision and port/group table commands of one subnet switch.
// ----------------------------------------------------------------------------
// Each request scans every table entry (16) in turn through a single shared
// address comparator, then applies the decision and table updates, and then
// loads the output register once it is free. Requests are taken one at a
// time; a new request is accepted once the previous result sits in the
// output register. The three packet counters wrap and are reported with
// every result.
module subnet_packet_forwarder (
    input  logic    clk,
    input  logic    rst_n,
    spf_in_if.sink  in_ch,
    spf_out_if.source out_ch,
    spf_cfg_if.sink cfg
);

    localparam int IW = spf_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] subnet_reg, mask_reg;
    logic        has_up_reg, same_net_reg;

    logic [2:0]    cmd_reg;
    logic [31:0]   addr_reg;
    logic [3:0]    port_reg;
    logic          from_up_reg;
    logic [IW-1:0] idx_reg;

    logic [spf_pkg::PORTS-1:0]  port_connected_reg, port_in_map_reg;
    logic [31:0]                port_address_reg [spf_pkg::PORTS];
    logic [spf_pkg::GROUPS-1:0] group_valid_reg;
    logic [31:0]                group_address_reg [spf_pkg::GROUPS];
    logic [spf_pkg::PORTS-1:0]  group_members_reg [spf_pkg::GROUPS];
    logic [spf_pkg::PORTS-1:0]  members_cap_reg;

    logic [31:0] local_cnt_reg, mc_cnt_reg, up_cnt_reg;
    logic [31:0] local_cnt_next, mc_cnt_next, up_cnt_next;

    logic [2:0]                res_action_reg, res_action_next;
    logic [spf_pkg::PORTS-1:0] res_mask_reg, res_mask_next;
    logic                      res_children_reg, res_children_next;
    logic [2:0]                res_status_reg, res_status_next;

    logic                      out_valid_reg;
    logic [2:0]                out_action_reg;
    logic [spf_pkg::PORTS-1:0] out_mask_reg;
    logic                      out_children_reg;
    logic [2:0]                out_status_reg;
    logic [31:0]               out_local_reg, out_mc_reg, out_up_reg;

    logic                  in_acc;
    logic                  is_local, is_mc, pass_up;
    logic [spf_pkg::PORTS-1:0] port_bit;
    spf_pkg::scan_entry_t  entry;
    spf_pkg::scan_hits_t   hits;
    logic                  grp_first;

    assign in_acc      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    assign pass_up  = !from_up_reg && same_net_reg && has_up_reg;
    assign is_local = ((addr_reg & mask_reg) == subnet_reg) || (addr_reg == spf_pkg::ALL_ONES);
    assign is_mc    = ((addr_reg & spf_pkg::MC_NIBBLE_MASK) == spf_pkg::MC_NIBBLE);
    assign port_bit = spf_pkg::PORTS'(1) << port_reg;

    always_comb
    begin
        entry.use_group = (cmd_reg == spf_pkg::CMD_SUBSCRIBE)
                       || (cmd_reg == spf_pkg::CMD_UNSUBSCRIBE)
                       || ((cmd_reg == spf_pkg::CMD_ROUTE) && !is_local);
        entry.addr      = entry.use_group ? group_address_reg[idx_reg]
                                          : port_address_reg[idx_reg];
        entry.in_map    = port_in_map_reg[idx_reg];
        entry.connected = port_connected_reg[idx_reg];
        entry.grp_valid = group_valid_reg[idx_reg];
    end

    spf_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_acc),
        .step      (state_reg == S_SCAN),
        .idx       (idx_reg),
        .key       (addr_reg),
        .entry     (entry),
        .hits      (hits),
        .grp_first (grp_first)
    );

    // decide
    always_comb
    begin
        res_action_next   = spf_pkg::ACT_DROP;
        res_mask_next     = '0;
        res_children_next = 1'b0;
        res_status_next   = spf_pkg::ST_OK;
        local_cnt_next    = local_cnt_reg;
        mc_cnt_next       = mc_cnt_reg;
        up_cnt_next       = up_cnt_reg;
        unique case (cmd_reg)
            spf_pkg::CMD_ROUTE:
            begin
                if (pass_up)
                begin
                    res_action_next = spf_pkg::ACT_PASS_UP;
                end
                else if (is_local)
                begin
                    local_cnt_next    = local_cnt_reg + 32'd1;
                    res_children_next = 1'b1;
                    if ((addr_reg == spf_pkg::ALL_ONES) || (addr_reg == (subnet_reg | ~mask_reg)))
                    begin
                        res_action_next = spf_pkg::ACT_BROADCAST;
                        res_mask_next   = port_connected_reg;
                    end
                    else
                    begin
                        res_action_next = spf_pkg::ACT_UNICAST;
                        if (hits.map_v)
                            res_mask_next = spf_pkg::PORTS'(1) << hits.map_idx;
                        else if (hits.conn_v)
                            res_mask_next = spf_pkg::PORTS'(1) << hits.conn_idx;
                        else
                            res_status_next = spf_pkg::ST_NO_DEVICE;
                    end
                end
                else if (is_mc)
                begin
                    res_children_next = 1'b1;
                    res_action_next   = spf_pkg::ACT_MULTICAST;
                    mc_cnt_next       = mc_cnt_reg + 32'd1;
                    if (hits.grp_v)
                        res_mask_next = members_cap_reg;
                    else
                        res_status_next = spf_pkg::ST_NO_LISTENER;
                end
                else if (has_up_reg && !from_up_reg)
                begin
                    res_action_next = spf_pkg::ACT_UPSTREAM;
                    up_cnt_next     = up_cnt_reg + 32'd1;
                end
            end
            spf_pkg::CMD_CONNECT:
            begin
                if (port_connected_reg[port_reg])
                    res_status_next = spf_pkg::ST_ALREADY;
                else if (addr_reg == '0)
                    res_status_next = spf_pkg::ST_NO_ADDRESS;
                else if (hits.map_v)
                    res_status_next = spf_pkg::ST_DUPLICATE;
            end
            spf_pkg::CMD_SUBSCRIBE:
            begin
                if (!hits.grp_v && !hits.free_v)
                    res_status_next = spf_pkg::ST_FULL;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc) state_next = S_SCAN;
            S_SCAN: if (idx_reg == IW'(spf_pkg::PORTS - 1)) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (!out_valid_reg || out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            subnet_reg         <= '0;
            mask_reg           <= '0;
            has_up_reg         <= 1'b0;
            same_net_reg       <= 1'b0;
            idx_reg            <= '0;
            port_connected_reg <= '0;
            port_in_map_reg    <= '0;
            group_valid_reg    <= '0;
            local_cnt_reg      <= '0;
            mc_cnt_reg         <= '0;
            up_cnt_reg         <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    spf_pkg::REG_SUBNET:       subnet_reg   <= cfg.data;
                    spf_pkg::REG_SUBNET_MASK:  mask_reg     <= cfg.data;
                    spf_pkg::REG_HAS_UPSTREAM: has_up_reg   <= cfg.data[0];
                    spf_pkg::REG_SAME_NET:     same_net_reg <= cfg.data[0];
                    default: ;
                endcase
            end
            if (in_acc)
                idx_reg <= '0;
            else if (state_reg == S_SCAN)
                idx_reg <= idx_reg + IW'(1);
            if (state_reg == S_EXEC)
            begin
                local_cnt_reg <= local_cnt_next;
                mc_cnt_reg    <= mc_cnt_next;
                up_cnt_reg    <= up_cnt_next;
                if (cmd_reg == spf_pkg::CMD_CONNECT && !port_connected_reg[port_reg])
                begin
                    port_connected_reg[port_reg] <= 1'b1;
                    port_in_map_reg[port_reg]    <= (addr_reg != '0) && !hits.map_v;
                end
                if (cmd_reg == spf_pkg::CMD_DISCONNECT)
                begin
                    port_connected_reg[port_reg] <= 1'b0;
                    port_in_map_reg[port_reg]    <= 1'b0;
                end
                if (cmd_reg == spf_pkg::CMD_SUBSCRIBE && !hits.grp_v && hits.free_v)
                    group_valid_reg[hits.free_idx] <= 1'b1;
            end
            if (state_reg == S_OUT && (!out_valid_reg || out_ch.ready))
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg     <= in_ch.cmd;
            addr_reg    <= in_ch.address;
            port_reg    <= in_ch.port;
            from_up_reg <= in_ch.from_upstream;
        end
        if (grp_first)
            members_cap_reg <= group_members_reg[idx_reg];
        // drop the leaving port from each group as the scan passes it
        if (state_reg == S_SCAN && cmd_reg == spf_pkg::CMD_DISCONNECT)
            group_members_reg[idx_reg] <= group_members_reg[idx_reg] & ~port_bit;
        if (state_reg == S_EXEC)
        begin
            res_action_reg   <= res_action_next;
            res_mask_reg     <= res_mask_next;
            res_children_reg <= res_children_next;
            res_status_reg   <= res_status_next;
            if (cmd_reg == spf_pkg::CMD_CONNECT && !port_connected_reg[port_reg])
                port_address_reg[port_reg] <= addr_reg;
            if (cmd_reg == spf_pkg::CMD_SUBSCRIBE)
            begin
                if (hits.grp_v)
                    group_members_reg[hits.grp_idx] <= members_cap_reg | port_bit;
                else if (hits.free_v)
                begin
                    group_address_reg[hits.free_idx] <= addr_reg;
                    group_members_reg[hits.free_idx] <= port_bit;
                end
            end
            if (cmd_reg == spf_pkg::CMD_UNSUBSCRIBE && hits.grp_v)
                group_members_reg[hits.grp_idx] <= members_cap_reg & ~port_bit;
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ch.ready))
        begin
            out_action_reg   <= res_action_reg;
            out_mask_reg     <= res_mask_reg;
            out_children_reg <= res_children_reg;
            out_status_reg   <= res_status_reg;
            out_local_reg    <= local_cnt_reg;
            out_mc_reg       <= mc_cnt_reg;
            out_up_reg       <= up_cnt_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.action          = out_action_reg;
    assign out_ch.port_mask       = out_mask_reg;
    assign out_ch.to_children     = out_children_reg;
    assign out_ch.status          = out_status_reg;
    assign out_ch.unicast_count   = out_local_reg;
    assign out_ch.multicast_count = out_mc_reg;
    assign out_ch.upstream_count  = out_up_reg;

`ifndef SYNTHESIS
    a_map_needs_connect: assert property (@(posedge clk) disable iff (!rst_n)
        (port_in_map_reg & ~port_connected_reg) == '0)
        else $error("mapped port not connected");

    a_groups_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (group_valid_reg & $past(group_valid_reg)) == $past(group_valid_reg))
        else $error("group entry freed");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (idx_reg == IW'(spf_pkg::PORTS - 1)) |=> (state_reg == S_EXEC))
        else $error("scan did not end at last entry");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_SCAN) && (idx_reg == '0))
        else $error("request did not start a scan");
`endif

endmodule

// ----- hdl/spf_scan.sv -----
// ----------------------------------------------------------------------------
// spf_scan
// Shared address comparator with first-hit trackers for table scans.
// ----------------------------------------------------------------------------
module spf_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            step,
    input  logic [spf_pkg::IDX_W-1:0]       idx,
    input  logic [31:0]                     key,
    input  spf_pkg::scan_entry_t            entry,
    output spf_pkg::scan_hits_t             hits,
    output logic                            grp_first
);

    spf_pkg::scan_hits_t hits_reg;
    spf_pkg::scan_hits_t hits_next;
    logic                eq;

    assign eq = (key == entry.addr);
    assign grp_first = step && entry.use_group && !hits_reg.grp_v && entry.grp_valid && eq;

    always_comb
    begin
        hits_next = hits_reg;
        if (start)
        begin
            hits_next.map_v  = 1'b0;
            hits_next.conn_v = 1'b0;
            hits_next.grp_v  = 1'b0;
            hits_next.free_v = 1'b0;
        end
        else if (step)
        begin
            if (!entry.use_group)
            begin
                if (!hits_reg.map_v && entry.in_map && eq)
                begin
                    hits_next.map_v   = 1'b1;
                    hits_next.map_idx = idx;
                end
                if (!hits_reg.conn_v && entry.connected && eq)
                begin
                    hits_next.conn_v   = 1'b1;
                    hits_next.conn_idx = idx;
                end
            end
            else
            begin
                if (grp_first)
                begin
                    hits_next.grp_v   = 1'b1;
                    hits_next.grp_idx = idx;
                end
                if (!hits_reg.free_v && !entry.grp_valid)
                begin
                    hits_next.free_v   = 1'b1;
                    hits_next.free_idx = idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
        end
        else
        begin
            hits_reg <= hits_next;
        end
    end

    assign hits = hits_reg;

endmodule
